@@ src/ptt_pkg.sv @@
// Shared types and constants for the polynomial term table.
package ptt_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam logic [2:0] K_PUSH   = 3'd0;
  localparam logic [2:0] K_POP    = 3'd1;
  localparam logic [2:0] K_REDUCE = 3'd2;
  localparam logic [2:0] K_LIST   = 3'd3;
  localparam logic [2:0] K_DERIV  = 3'd4;

  localparam logic [1:0] ST_TERM  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FIND, S_FIND_END, S_DECIDE,
    S_SUM, S_SUM_END, S_WRITE, S_EMIT_RD, S_EMIT_LD
  } ctl_state_t;

  typedef struct packed {
    logic       take;
    logic       push_wr;
    logic       pop;
    logic       red_init;
    logic       find_clr;
    logic       sum_clr;
    logic       rd;
    logic       rd_find;
    logic       rd_sum;
    logic       red_wr;
    logic       red_end;
    logic       emit_clr;
    logic       out_term;
    logic       out_stat;
    logic [1:0] stat;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       full;
    logic       empty;
    logic       scan_last;
    logic       found;
    logic       emit_last;
    logic [2:0] kind;
  } dp_status_t;

endpackage

@@ src/ptt_if.sv @@
// Channel interfaces for commands and results.
interface ptt_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] coefficient;
  logic signed [7:0]  exponent;
  modport source (output valid, kind, coefficient, exponent, input ready);
  modport sink (input valid, kind, coefficient, exponent, output ready);
endinterface

interface ptt_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [23:0] out_coefficient;
  logic signed [8:0]  out_exponent;
  logic               last;
  modport source (output valid, status, out_coefficient, out_exponent, last, input ready);
  modport sink (input valid, status, out_coefficient, out_exponent, last, output ready);
endinterface

@@ src/ptt_datapath.sv @@
// Term storage, scan counters, merge/sort arithmetic and result register.
module ptt_datapath #(
  parameter int MAX_TERMS = ptt_pkg::MAX_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptt_pkg::dp_cmd_t    cmd,
  output ptt_pkg::dp_status_t st,
  ptt_cmd_if.sink             command,
  ptt_res_if.source           result
);
  import ptt_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = $clog2(MAX_TERMS);
  localparam int DEPTH = 2 ** (IW + 1);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data;

  logic [CW-1:0] count, j, k, phys;
  logic          bank;
  logic [2:0]    kind;
  logic signed [15:0] in_coef, acc;
  logic signed [7:0]  in_expo, cand, prev;
  logic          found, have_prev, p_find, p_sum;

  logic               wr_en;
  logic [IW:0]        wr_addr, rd_addr;
  logic [23:0]        wr_data;
  logic signed [15:0] tc;
  logic signed [7:0]  te;
  logic signed [16:0] sum;
  logic signed [15:0] sat;
  logic signed [23:0] prod;

  assign phys    = count - j - CW'(1);
  assign rd_addr = {bank, phys[IW-1:0]};
  assign wr_en   = cmd.push_wr | cmd.red_wr;
  assign wr_addr = cmd.push_wr ? {bank, count[IW-1:0]} : {~bank, k[IW-1:0]};
  assign wr_data = cmd.push_wr ? {in_coef, in_expo} : {acc, cand};

  assign tc   = rd_data[23:8];
  assign te   = rd_data[7:0];
  assign sum  = {acc[15], acc} + {tc[15], tc};
  assign prod = 24'(tc) * 24'(te);

  always_comb begin
    if (sum[16] != sum[15]) begin
      sat = sum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      bank   <= 1'b0;
      p_find <= 1'b0;
      p_sum  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      p_find <= cmd.rd & cmd.rd_find;
      p_sum  <= cmd.rd & cmd.rd_sum;
      if (cmd.take) begin
        kind    <= command.kind;
        in_coef <= command.coefficient;
        in_expo <= command.exponent;
      end
      if (cmd.push_wr) count <= count + CW'(1);
      if (cmd.pop) count <= count - CW'(1);
      if (cmd.find_clr || cmd.sum_clr || cmd.emit_clr) j <= '0;
      else if (cmd.rd) j <= j + CW'(1);
      if (cmd.find_clr) found <= 1'b0;
      if (cmd.sum_clr) acc <= '0;
      if (cmd.red_init) begin
        k <= '0;
        have_prev <= 1'b0;
      end
      // smallest exponent above the previous pick
      if (p_find && (!have_prev || te > prev) && (!found || te < cand)) begin
        cand  <= te;
        found <= 1'b1;
      end
      if (p_sum && te == cand) acc <= sat;
      if (cmd.red_wr) begin
        k <= k + CW'(1);
        prev <= cand;
        have_prev <= 1'b1;
      end
      if (cmd.red_end) begin
        bank  <= ~bank;
        count <= k;
      end
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (cmd.out_stat) begin
        result.valid           <= 1'b1;
        result.status          <= cmd.stat;
        result.out_coefficient <= '0;
        result.out_exponent    <= '0;
        result.last            <= 1'b1;
      end
      if (cmd.out_term) begin
        result.valid  <= 1'b1;
        result.status <= ST_TERM;
        result.last   <= (j == count);
        if (kind == K_DERIV) begin
          result.out_coefficient <= prod;
          result.out_exponent    <= 9'(te) - 9'sd1;
        end else begin
          result.out_coefficient <= 24'(tc);
          result.out_exponent    <= 9'(te);
        end
      end
    end
  end

  assign st.busy      = result.valid;
  assign st.full      = (count == CW'(MAX_TERMS));
  assign st.empty     = (count == '0);
  assign st.scan_last = (j == count - CW'(1));
  assign st.found     = found;
  assign st.emit_last = (j == count);
  assign st.kind      = kind;

endmodule

@@ src/ptt_ctrl.sv @@
// Command sequencer for the polynomial term table.
module ptt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ptt_pkg::dp_status_t st,
  output ptt_pkg::dp_cmd_t    cmd
);
  import ptt_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.take = cmd_valid;
        if (cmd_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!st.busy) begin
          state_next = S_IDLE;
          case (st.kind) inside
            K_PUSH: begin
              cmd.out_stat = 1'b1;
              cmd.stat = st.full ? ST_FULL : ST_DONE;
              cmd.push_wr = !st.full;
            end
            K_POP: begin
              cmd.out_stat = 1'b1;
              cmd.stat = st.empty ? ST_EMPTY : ST_DONE;
              cmd.pop = !st.empty;
            end
            K_REDUCE, K_LIST, K_DERIV: begin
              if (st.empty) begin
                cmd.out_stat = 1'b1;
                cmd.stat = ST_EMPTY;
              end else if (st.kind == K_REDUCE) begin
                cmd.red_init = 1'b1;
                cmd.find_clr = 1'b1;
                state_next = S_FIND;
              end else begin
                cmd.emit_clr = 1'b1;
                state_next = S_EMIT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        cmd.rd = 1'b1;
        cmd.rd_find = 1'b1;
        if (st.scan_last) state_next = S_FIND_END;
      end
      S_FIND_END: state_next = S_DECIDE;
      S_DECIDE: begin
        if (st.found) begin
          cmd.sum_clr = 1'b1;
          state_next = S_SUM;
        end else begin
          cmd.red_end = 1'b1;
          cmd.emit_clr = 1'b1;
          state_next = S_EMIT_RD;
        end
      end
      S_SUM: begin
        cmd.rd = 1'b1;
        cmd.rd_sum = 1'b1;
        if (st.scan_last) state_next = S_SUM_END;
      end
      S_SUM_END: state_next = S_WRITE;
      S_WRITE: begin
        cmd.red_wr = 1'b1;
        cmd.find_clr = 1'b1;
        state_next = S_FIND;
      end
      S_EMIT_RD: begin
        if (!st.busy) begin
          cmd.rd = 1'b1;
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.out_term = 1'b1;
        state_next = st.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/polynomial_term_table_top.sv @@
// Top level of the polynomial term table: sequencer plus datapath.
// Push and pop each answer with a single status transaction once any pending result is taken.
// List and derivative read each term from the term memory and register it as a result;
// the next term is read only after the previous result is taken. Reduce reads every
// term once to find each next exponent and once to sum its coefficients, then lists them.
// One command at a time; sync reset empties the table and drops any result.
module polynomial_term_table_top #(
  parameter int MAX_TERMS = ptt_pkg::MAX_TERMS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptt_cmd_if.sink   command,
  ptt_res_if.source result
);
  import ptt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer: find and sum scan states for reduce, read and load states per emitted term
  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (command.valid),
    .cmd_ready (command.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: two-bank term memory; reduce rebuilds into the idle bank
  ptt_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .command (command),
    .result  (result)
  );

endmodule

@@ src/ptt_checker.sv @@
// Port-level checks for the polynomial term table, bound to the top level.
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [23:0] out_coefficient,
  input logic [8:0]  out_exponent,
  input logic        last
);
  import ptt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second command taken while busy");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TERM |-> last) else $error("status transaction not last");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TERM |-> out_coefficient == '0 && out_exponent == '0)
    else $error("status transaction carries a term");

endmodule

bind polynomial_term_table_top ptt_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (command.valid),
  .in_ready        (command.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .status          (result.status),
  .out_coefficient (result.out_coefficient),
  .out_exponent    (result.out_exponent),
  .last            (result.last)
);
